[rtl/core/sks_pkg.sv]
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and defaults for the string key insertion sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

  localparam int unsigned MaxRecordsDef = 16;
  localparam int unsigned KeyBytesDef   = 50;
  localparam int unsigned RecNumW       = 4;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ZFILL,
    ST_INIT,
    ST_OUTER,
    ST_INNER,
    ST_KEY_RD,
    ST_KEY_CMP,
    ST_PLACE,
    ST_OUT_RD,
    ST_OUT_LOAD
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic fill;
    logic sort_init;
    logic outer_set;
    logic ord_rd;
    logic key_rd;
    logic w_inc;
    logic shift_wr;
    logic place_wr;
    logic out_init;
    logic out_rd;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fin_short;
    logic fill_last;
    logic i_eq_n;
    logic j_zero;
    logic cmp_done;
    logic cmp_after;
    logic out_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[rtl/core/sks_ctrl.sv]
// ----------------------------------------------------------------------------
// sks_ctrl
// Sequencer: load, zero fill of a short last key, insertion sort, readout.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          final_record_i,
  output logic               in_stall_o,
  input  wire sks_pkg::sts_t sts_i,
  output sks_pkg::cmd_t      cmd_o
);

  sks_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sks_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sks_pkg::ST_LOAD: begin
        if (in_valid_i && final_record_i) begin
          state_d = sts_i.fin_short ? sks_pkg::ST_ZFILL : sks_pkg::ST_INIT;
        end
      end
      sks_pkg::ST_ZFILL: begin
        if (sts_i.fill_last) state_d = sks_pkg::ST_INIT;
      end
      sks_pkg::ST_INIT:   state_d = sks_pkg::ST_OUTER;
      sks_pkg::ST_OUTER: begin
        state_d = sts_i.i_eq_n ? sks_pkg::ST_OUT_RD : sks_pkg::ST_INNER;
      end
      sks_pkg::ST_INNER: begin
        state_d = sts_i.j_zero ? sks_pkg::ST_PLACE : sks_pkg::ST_KEY_RD;
      end
      sks_pkg::ST_KEY_RD: state_d = sks_pkg::ST_KEY_CMP;
      sks_pkg::ST_KEY_CMP: begin
        if (sts_i.cmp_done) begin
          state_d = sts_i.cmp_after ? sks_pkg::ST_INNER : sks_pkg::ST_PLACE;
        end else begin
          state_d = sks_pkg::ST_KEY_RD;
        end
      end
      sks_pkg::ST_PLACE:  state_d = sks_pkg::ST_OUTER;
      sks_pkg::ST_OUT_RD: state_d = sks_pkg::ST_OUT_LOAD;
      sks_pkg::ST_OUT_LOAD: begin
        if (sts_i.out_free) begin
          state_d = sts_i.out_last ? sks_pkg::ST_LOAD : sks_pkg::ST_OUT_RD;
        end
      end
      default: state_d = sks_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      sks_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      sks_pkg::ST_ZFILL:  cmd_o.fill = 1'b1;
      sks_pkg::ST_INIT:   cmd_o.sort_init = 1'b1;
      sks_pkg::ST_OUTER: begin
        cmd_o.outer_set = !sts_i.i_eq_n;
        cmd_o.out_init  = sts_i.i_eq_n;
      end
      sks_pkg::ST_INNER:  cmd_o.ord_rd = !sts_i.j_zero;
      sks_pkg::ST_KEY_RD: cmd_o.key_rd = 1'b1;
      sks_pkg::ST_KEY_CMP: begin
        cmd_o.w_inc    = !sts_i.cmp_done;
        cmd_o.shift_wr = sts_i.cmp_done && sts_i.cmp_after;
      end
      sks_pkg::ST_PLACE:    cmd_o.place_wr = 1'b1;
      sks_pkg::ST_OUT_RD:   cmd_o.out_rd = 1'b1;
      sks_pkg::ST_OUT_LOAD: cmd_o.out_load = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/sks_dp.sv]
// ----------------------------------------------------------------------------
// sks_dp
// Key store, order list, counters, word comparator and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_dp #(
  parameter int unsigned MaxRecords = sks_pkg::MaxRecordsDef,
  parameter int unsigned KeyBytes   = sks_pkg::KeyBytesDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [63:0]   name_slice_i,
  input  wire logic          final_record_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_descending_i,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output logic [sks_pkg::RecNumW-1:0] record_number_o,
  output logic               last_of_run_o,
  output logic               records_dropped_o,
  input  wire sks_pkg::cmd_t cmd_i,
  output sks_pkg::sts_t      sts_o
);

  localparam int unsigned KeyWords = (KeyBytes + 7) / 8;
  localparam int unsigned WB       = (KeyWords > 1) ? $clog2(KeyWords) : 1;
  localparam int unsigned RW       = $clog2(MaxRecords);
  localparam int unsigned CW       = $clog2(MaxRecords + 1);
  localparam int unsigned GW       = WB + 4;
  localparam int unsigned KDepth   = MaxRecords << WB;

  // rows are padded to a power-of-two number of words
  logic [63:0] key_mem [KDepth];
  logic [RW-1:0] ord_mem [MaxRecords];

  logic          desc_q;
  logic [CW-1:0] rec_cnt_q, rec_cnt_d;
  logic [WB-1:0] slc_q, slc_d;
  logic          ovf_q, ovf_d;
  logic [RW-1:0] fill_row_q;
  logic [WB-1:0] fill_w_q;
  logic [CW-1:0] i_q;
  logic [RW-1:0] j_q;
  logic [WB-1:0] w_q;
  logic [RW-1:0] ord_q;
  logic [63:0]   ka_q, kb_q;
  logic          out_valid_q;
  logic [sks_pkg::RecNumW-1:0] rec_num_q;
  logic          last_q, drop_q;

  logic          room;
  logic          rec_end;
  logic [RW-1:0] x_idx;
  logic [RW+sks_pkg::RecNumW-1:0] ord_ext;
  logic          found, a_lt, a_gt;

  assign room    = rec_cnt_q < CW'(MaxRecords);
  assign rec_end = (slc_q == WB'(KeyWords - 1)) || final_record_i;
  assign x_idx   = i_q[RW-1:0];
  assign ord_ext = {{sks_pkg::RecNumW{1'b0}}, ord_q};

  // load counters
  always_comb begin
    rec_cnt_d = rec_cnt_q;
    slc_d     = slc_q;
    ovf_d     = ovf_q;
    if (cmd_i.load) begin
      if (rec_end) begin
        slc_d = '0;
        if (room) rec_cnt_d = rec_cnt_q + CW'(1);
        else      ovf_d = 1'b1;
      end else begin
        slc_d = slc_q + WB'(1);
      end
    end else if (cmd_i.out_load && sts_o.out_last) begin
      rec_cnt_d = '0;
      slc_d     = '0;
      ovf_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q      <= 1'b0;
      rec_cnt_q   <= '0;
      slc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) desc_q <= cfg_descending_i;
      rec_cnt_q <= rec_cnt_d;
      slc_q     <= slc_d;
      ovf_q     <= ovf_d;
      if (cmd_i.out_load)    out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // sort indices and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fill_row_q <= rec_cnt_q[RW-1:0];
      fill_w_q   <= slc_q + WB'(1);
    end else if (cmd_i.fill) begin
      fill_w_q <= fill_w_q + WB'(1);
    end
    if (cmd_i.sort_init || cmd_i.out_init) begin
      i_q <= '0;
    end else if (cmd_i.place_wr || cmd_i.out_load) begin
      i_q <= i_q + CW'(1);
    end
    if (cmd_i.outer_set) begin
      j_q <= x_idx;
    end else if (cmd_i.shift_wr) begin
      j_q <= j_q - RW'(1);
    end
    if (cmd_i.ord_rd) begin
      w_q <= '0;
    end else if (cmd_i.w_inc) begin
      w_q <= w_q + WB'(1);
    end
    if (cmd_i.out_load) begin
      rec_num_q <= ord_ext[sks_pkg::RecNumW-1:0];
      last_q    <= sts_o.out_last;
      drop_q    <= ovf_q;
    end
  end

  // key store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      key_mem[{rec_cnt_q[RW-1:0], slc_q}] <= name_slice_i;
    end else if (cmd_i.fill) begin
      key_mem[{fill_row_q, fill_w_q}] <= '0;
    end
    if (cmd_i.key_rd) begin
      ka_q <= key_mem[{ord_q, w_q}];
      kb_q <= key_mem[{x_idx, w_q}];
    end
  end

  // order list
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_wr) begin
      ord_mem[j_q] <= ord_q;
    end else if (cmd_i.place_wr) begin
      ord_mem[j_q] <= x_idx;
    end
    if (cmd_i.ord_rd) begin
      ord_q <= ord_mem[j_q - RW'(1)];
    end else if (cmd_i.out_rd) begin
      ord_q <= ord_mem[x_idx];
    end
  end

  // one word of strcmp: stop at first difference or at a NUL,
  // bytes past the key length read as zero
  always_comb begin
    logic [7:0]    ca, cb;
    logic [GW-1:0] gidx;
    found = 1'b0;
    a_lt  = 1'b0;
    a_gt  = 1'b0;
    for (int k = 0; k < 8; k++) begin
      gidx = {1'b0, w_q, 3'(k)};
      ca   = ka_q[63-8*k -: 8];
      cb   = kb_q[63-8*k -: 8];
      if (gidx >= GW'(KeyBytes)) begin
        ca = '0;
        cb = '0;
      end
      if (!found) begin
        if (ca != cb) begin
          found = 1'b1;
          a_lt  = ca < cb;
          a_gt  = ca > cb;
        end else if (ca == 8'd0) begin
          found = 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.fin_short = final_record_i && room && (slc_q != WB'(KeyWords - 1));
    sts_o.fill_last = fill_w_q == WB'(KeyWords - 1);
    sts_o.i_eq_n    = i_q == rec_cnt_q;
    sts_o.j_zero    = j_q == '0;
    sts_o.cmp_done  = found || (w_q == WB'(KeyWords - 1));
    sts_o.cmp_after = desc_q ? a_lt : a_gt;
    sts_o.out_last  = (i_q + CW'(1)) == rec_cnt_q;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o       = out_valid_q;
  assign record_number_o   = rec_num_q;
  assign last_of_run_o     = last_q;
  assign records_dropped_o = drop_q;

  a_rec_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_cnt_q <= CW'(MaxRecords))
    else $error("record count above capacity");

  a_key_rows_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.key_rd |-> ((CW'(ord_q) < rec_cnt_q) && (i_q < rec_cnt_q)))
    else $error("key read of a row not loaded in this batch");

  a_key_rows_differ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.key_rd |-> (ord_q != x_idx))
    else $error("record compared against itself");

  a_shift_not_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_wr |-> (j_q != '0))
    else $error("shift past head of order list");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> sts_o.out_free)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

[rtl/core/string_key_insertion_sort_top.sv]
// Sequence: slices are taken while loading; after the final slice a short last
// key is zero filled word by word. The sort sets up, then inserts each record,
// comparing keys a word at a time; readout then streams the record numbers.
// Throughput: one batch at a time; no slice is taken while sorting or reading.
// Reset: asynchronous, active low; clears counters, state and the descending flag.
// ----------------------------------------------------------------------------
// string_key_insertion_sort_top
// Loads text keys by 64-bit slices, sorts record numbers by key, streams them.
// ----------------------------------------------------------------------------
`default_nettype none

module string_key_insertion_sort_top #(
  parameter int unsigned MaxRecords = sks_pkg::MaxRecordsDef,
  parameter int unsigned KeyBytes   = sks_pkg::KeyBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] name_slice_i,
  input  wire logic        final_record_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [sks_pkg::RecNumW-1:0] record_number_o,
  output logic             last_of_run_o,
  output logic             records_dropped_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_descending_i
);

  sks_pkg::cmd_t cmd;
  sks_pkg::sts_t sts;

  sks_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .final_record_i (final_record_i),
    .in_stall_o     (in_stall_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  sks_dp #(
    .MaxRecords (MaxRecords),
    .KeyBytes   (KeyBytes)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .name_slice_i      (name_slice_i),
    .final_record_i    (final_record_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_descending_i  (cfg_descending_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .record_number_o   (record_number_o),
    .last_of_run_o     (last_of_run_o),
    .records_dropped_o (records_dropped_o),
    .cmd_i             (cmd),
    .sts_o             (sts)
  );

endmodule

`default_nettype wire

[tb/sks_order_checker.sv]
// ----------------------------------------------------------------------------
// sks_order_checker
// Watches the slice, config and result channels of the string key sorter,
// predicts the sorted record numbers of each batch and compares every result.
// ----------------------------------------------------------------------------

module sks_order_checker #(
  parameter int unsigned MaxRecords = sks_pkg::MaxRecordsDef,
  parameter int unsigned KeyBytes   = sks_pkg::KeyBytesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [63:0]                 name_slice_i,
  input  logic                        final_record_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [sks_pkg::RecNumW-1:0] record_number_i,
  input  logic                        last_of_run_i,
  input  logic                        records_dropped_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_descending_i,
  output int                          errors_o,
  output int                          pending_o
);

  localparam int unsigned KeyWords = (KeyBytes + 7) / 8;

  typedef struct packed {
    logic [sks_pkg::RecNumW-1:0] rec;
    logic                        last;
    logic                        dropped;
  } rank_t;

  logic [63:0] name_mem [MaxRecords][KeyWords];
  int unsigned rank_list [MaxRecords];
  int unsigned n_loaded;
  int unsigned word_pos;
  logic        spilled;
  logic        desc_mode;
  rank_t       ranks_due_q [$];
  int unsigned mismatches;

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic        room;
    logic        stop;
    int unsigned n;
    int unsigned x;
    int unsigned j;
    int unsigned prev;
    int          c;
    logic [63:0] wa;
    logic [63:0] wb;
    logic [7:0]  ca;
    logic [7:0]  cb;
    rank_t       r;
    rank_t       got;

    if (!rst_ni) begin
      ranks_due_q.delete();
      n_loaded   = 0;
      word_pos   = 0;
      spilled    = 1'b0;
      desc_mode  = 1'b0;
      mismatches = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) desc_mode = cfg_descending_i;

      // results are checked before slices taken in the same cycle
      if (out_valid_i && !out_stall_i) begin
        got = {record_number_i, last_of_run_i, records_dropped_i};
        if (ranks_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result record %0d last %0b dropped %0b",
                     $time, got.rec, got.last, got.dropped);
        end else begin
          r = ranks_due_q.pop_front();
          if (got != r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch record %0d last %0b dropped %0b, expected %0d %0b %0b",
                       $time, got.rec, got.last, got.dropped, r.rec, r.last, r.dropped);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        room = (n_loaded < MaxRecords);
        if (room) begin
          // a new record starts from a zeroed key
          if (word_pos == 0)
            for (int unsigned w = 0; w < KeyWords; w++) name_mem[n_loaded][w] = '0;
          name_mem[n_loaded][word_pos] = name_slice_i;
        end
        word_pos++;
        if (word_pos >= KeyWords || final_record_i) begin
          word_pos = 0;
          if (room) n_loaded++;
          else spilled = 1'b1;
        end

        if (final_record_i) begin
          n = n_loaded;
          for (int unsigned i = 0; i < n; i++) begin
            x = i;
            j = i;
            while (j > 0) begin
              prev = rank_list[j - 1];
              c    = 0;
              stop = 1'b0;
              // strcmp over the compared length, unsigned bytes
              for (int unsigned k = 0; k < KeyBytes && !stop; k++) begin
                wa = name_mem[prev][k / 8];
                wb = name_mem[x][k / 8];
                ca = wa[(7 - k % 8) * 8 +: 8];
                cb = wb[(7 - k % 8) * 8 +: 8];
                if (ca != cb) begin
                  c    = (ca < cb) ? -1 : 1;
                  stop = 1'b1;
                end else if (ca == 8'h00) begin
                  stop = 1'b1;
                end
              end
              if (desc_mode ? (c >= 0) : (c <= 0)) break;
              rank_list[j] = prev;
              j--;
            end
            rank_list[j] = x;
          end
          for (int unsigned i = 0; i < n; i++) begin
            r.rec     = rank_list[i][sks_pkg::RecNumW-1:0];
            r.last    = (i + 1 == n);
            r.dropped = spilled;
            ranks_due_q.push_back(r);
          end
          n_loaded = 0;
          word_pos = 0;
          spilled  = 1'b0;
        end
      end

      errors_o  <= mismatches;
      pending_o <= ranks_due_q.size();
    end
  end

endmodule

[tb/string_key_insertion_sort_top_test.sv]
// ----------------------------------------------------------------------------
// string_key_insertion_sort_top_test
// Drives batches of text keys into the sorter with bursty input and random
// output stalls, switches the sort direction between phases, and reports the
// verdict from the order checker.
// ----------------------------------------------------------------------------

module string_key_insertion_sort_top_test;

  localparam int unsigned MaxRecords = sks_pkg::MaxRecordsDef;
  localparam int unsigned KeyWords   = (sks_pkg::KeyBytesDef + 7) / 8;
  localparam int unsigned KeyLen     = KeyWords * 8;
  localparam int unsigned IdleLimit  = 10000;
  localparam int unsigned PhaseItems = 125;
  localparam int unsigned HoldCycles = 300;
  localparam logic        OrderAsc   = 1'b0;
  localparam logic        OrderDesc  = 1'b1;

  typedef enum int unsigned {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BLOCK} rx_style_e;
  typedef enum int unsigned {KEY_NARROW, KEY_TEXT, KEY_RAW} key_style_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [63:0] name_slice = '0;
  logic        final_rec  = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [sks_pkg::RecNumW-1:0] rec_num;
  logic        last_run;
  logic        dropped;
  logic        cfg_we     = 1'b0;
  logic        cfg_desc   = 1'b0;
  int          errors;
  int          pending;

  logic [7:0]  key_bytes [KeyLen];
  logic [7:0]  prev_key  [KeyLen];
  int unsigned burst_left  = 0;
  int unsigned sent_items  = 0;
  int unsigned idle_cycles = 0;
  int unsigned taken       = 0;
  int unsigned mode_left   = 0;
  int unsigned hold_left   = 0;
  rx_style_e   rx_style    = RX_FREE;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  string_key_insertion_sort_top u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .name_slice_i      (name_slice),
    .final_record_i    (final_rec),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .record_number_o   (rec_num),
    .last_of_run_o     (last_run),
    .records_dropped_o (dropped),
    .cfg_we_i          (cfg_we),
    .cfg_descending_i  (cfg_desc)
  );

  sks_order_checker u_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .name_slice_i      (name_slice),
    .final_record_i    (final_rec),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .record_number_i   (rec_num),
    .last_of_run_i     (last_run),
    .records_dropped_i (dropped),
    .cfg_we_i          (cfg_we),
    .cfg_descending_i  (cfg_desc),
    .errors_o          (errors),
    .pending_o         (pending)
  );

  // result side: stall styles in random stretches, plus long hold-offs
  always @(posedge clk) begin
    if (out_valid && !out_stall) taken <= taken + 1;
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (out_valid && !out_stall && (taken == 20 || taken == 120)) begin
      out_stall <= 1'b1;
      hold_left <= HoldCycles;
    end else if (mode_left == 0) begin
      rx_style  <= rx_style_e'($urandom_range(0, 3));
      mode_left <= $urandom_range(5, 60);
      out_stall <= 1'b0;
    end else begin
      mode_left <= mode_left - 1;
      case (rx_style)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // offers one slice and holds it until taken; gaps open between bursts
  task automatic offer_slice(input logic [63:0] s, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    name_slice <= s;
    final_rec  <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic write_order(input logic d);
    cfg_we   <= 1'b1;
    cfg_desc <= d;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // wait for every outstanding result, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    int unsigned nrec;
    int unsigned nwords;
    int unsigned len;
    int unsigned mark;
    int unsigned batch;
    int unsigned tweak;
    key_style_e  style;
    logic        junk;
    logic        last_rec;
    logic [63:0] s;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_order(OrderAsc);
    // keys equal up to the NUL, different junk after it
    offer_slice(64'h6162_005A_5A5A_5A5A, 1'b0);
    repeat (KeyWords - 1) offer_slice(64'h0123_4567_89AB_CDEF, 1'b0);
    offer_slice(64'h6162_0000_0000_0000, 1'b1);
    drain();

    write_order(OrderDesc);
    // two keys that differ only past the compared length: a tie
    for (int unsigned r = 0; r < 2; r++) begin
      repeat (KeyWords - 1) offer_slice({8{8'h41}}, 1'b0);
      offer_slice((r == 0) ? 64'h4141_0000_0000_0000 : 64'h4141_FFFF_FFFF_FFFF, 1'b0);
    end
    // top byte 0xFF ranks above 'A' when compared unsigned
    offer_slice(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    drain();
    offer_slice(64'h0, 1'b1);
    drain();

    for (int unsigned ph = 0; ph < 4; ph++) begin
      write_order((ph % 2 == 0) ? OrderAsc : OrderDesc);
      mark  = sent_items;
      batch = 0;
      while (sent_items - mark < PhaseItems) begin
        if (batch == 0 && ph == 0) nrec = MaxRecords + 1;
        else if (batch == 0 && ph == 3) nrec = MaxRecords;
        else if ($urandom_range(0, 19) == 0) nrec = $urandom_range(8, MaxRecords + 4);
        else nrec = $urandom_range(1, 5);

        for (int unsigned r = 0; r < nrec; r++) begin
          if (r != 0 && $urandom_range(0, 3) == 0) begin
            // near copy of the previous key: exact tie, tail change, or one byte
            key_bytes = prev_key;
            tweak = $urandom_range(0, 2);
            if (tweak == 0) begin
              for (int unsigned k = sks_pkg::KeyBytesDef; k < KeyLen; k++)
                key_bytes[k] = 8'($urandom);
            end else if (tweak == 1) begin
              key_bytes[$urandom_range(0, KeyLen - 1)] = 8'($urandom);
            end
          end else begin
            len   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 6)
                                                : $urandom_range(0, KeyLen);
            style = key_style_e'($urandom_range(0, 2));
            junk  = 1'($urandom_range(0, 1));
            for (int unsigned k = 0; k < KeyLen; k++) begin
              if (k < len) begin
                case (style)
                  KEY_NARROW: key_bytes[k] = 8'h61 + 8'($urandom_range(0, 2));
                  KEY_TEXT:   key_bytes[k] = 8'($urandom_range(1, 255));
                  default:    key_bytes[k] = 8'($urandom);
                endcase
              end else if (k == len) begin
                key_bytes[k] = 8'h00;
              end else begin
                key_bytes[k] = junk ? 8'($urandom) : 8'h00;
              end
            end
          end
          prev_key = key_bytes;

          last_rec = (r + 1 == nrec);
          nwords   = last_rec ? $urandom_range(1, KeyWords) : KeyWords;
          for (int unsigned w = 0; w < nwords; w++) begin
            for (int unsigned b = 0; b < 8; b++) s[(7 - b) * 8 +: 8] = key_bytes[w * 8 + b];
            offer_slice(s, last_rec && (w + 1 == nwords));
          end
        end
        batch++;
      end
      drain();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
